>>> rtl/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

  // field widths fixed by the interface
  localparam int unsigned LINE_W     = 12;
  localparam int unsigned PAT_W      = 3;
  localparam int unsigned DUTY_W     = 11;
  localparam int unsigned PWM_W      = 8;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  // switch bitmaps that run a pattern
  localparam logic [PAT_W-1:0] PAT_ALT   = 3'd0;
  localparam logic [PAT_W-1:0] PAT_CHASE = 3'd1;

  // register indexes
  localparam logic [1:0] REG_PWM_PERIOD     = 2'd0;
  localparam logic [1:0] REG_BASE_DUTY      = 2'd1;
  localparam logic [1:0] REG_ALT_INTERVAL   = 2'd2;
  localparam logic [1:0] REG_CHASE_INTERVAL = 2'd3;

  // register reset values
  localparam logic [PWM_W-1:0]      PWM_PERIOD_RST     = 8'd10;
  localparam logic [PWM_W-1:0]      BASE_DUTY_RST      = 8'd1;
  localparam logic [INTERVAL_W-1:0] ALT_INTERVAL_RST   = 16'd500;
  localparam logic [INTERVAL_W-1:0] CHASE_INTERVAL_RST = 16'd100;

  localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [DUTY_W-1:0]     MIDDLE_GAIN = 11'd5;

  typedef struct packed {
    logic [PWM_W-1:0]      pwm_period;
    logic [PWM_W-1:0]      base_duty;
    logic [INTERVAL_W-1:0] alt_interval;
    logic [INTERVAL_W-1:0] chase_interval;
  } cfg_t;

  // per-tick commands from the sequencer to the led bank
  typedef struct packed {
    logic             tick;
    logic             clear;
    logic             alt_do;
    logic             alt_first;
    logic             chase_do;
    logic [PWM_W-1:0] pwm_cnt;
  } led_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lpd_cfg_regs.sv
`default_nettype none

module lpd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lpd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [lpd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output lpd_pkg::cfg_t                         cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period     <= lpd_pkg::PWM_PERIOD_RST;
      cfg.base_duty      <= lpd_pkg::BASE_DUTY_RST;
      cfg.alt_interval   <= lpd_pkg::ALT_INTERVAL_RST;
      cfg.chase_interval <= lpd_pkg::CHASE_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        lpd_pkg::REG_PWM_PERIOD:     cfg.pwm_period     <= pwdata[7:0];
        lpd_pkg::REG_BASE_DUTY:      cfg.base_duty      <= pwdata[7:0];
        lpd_pkg::REG_ALT_INTERVAL:   cfg.alt_interval   <= pwdata[15:0];
        lpd_pkg::REG_CHASE_INTERVAL: cfg.chase_interval <= pwdata[15:0];
        default:                     ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lpd_pkg::REG_PWM_PERIOD:     prdata = 32'(cfg.pwm_period);
      lpd_pkg::REG_BASE_DUTY:      prdata = 32'(cfg.base_duty);
      lpd_pkg::REG_ALT_INTERVAL:   prdata = 32'(cfg.alt_interval);
      lpd_pkg::REG_CHASE_INTERVAL: prdata = 32'(cfg.chase_interval);
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lpd_seq.sv
`default_nettype none

module lpd_seq #(
  parameter int unsigned NUM_LEDS = 12,
  parameter int unsigned LW       = $clog2(NUM_LEDS),
  parameter int unsigned SW       = $clog2(NUM_LEDS + 3)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          proc,
  input  wire logic                          req_type,
  input  wire logic [1:0]                    switch_index,
  input  wire logic                          switch_on,
  input  wire lpd_pkg::cfg_t                 cfg,
  output lpd_pkg::led_ctl_t                  ctl,
  output logic      [3:0][LW-1:0]            chase_idx,
  output logic      [lpd_pkg::PAT_W-1:0]     pattern_next
);

  localparam logic [SW-1:0] STEP_WRAP = SW'(NUM_LEDS + 2);
  localparam logic [SW:0]   LEDS_EXT  = (SW + 1)'(NUM_LEDS);

  logic [lpd_pkg::PAT_W-1:0]      switch_bits;
  logic [SW-1:0]                  step_index;
  logic [lpd_pkg::INTERVAL_W-1:0] elapsed_ticks;
  logic [lpd_pkg::PWM_W-1:0]      pwm_count;
  logic                           needs_clear;

  logic                           tick_do;
  logic                           ev_do;
  logic                           pat_on;
  logic                           act;
  logic [lpd_pkg::INTERVAL_W-1:0] elapsed_inc;
  logic [lpd_pkg::INTERVAL_W-1:0] interval;
  logic [lpd_pkg::PWM_W-1:0]      pwm_cur;
  logic [SW-1:0]                  chase_step;
  logic [SW:0]                    idx_sum;

  assign tick_do = proc && (req_type == lpd_pkg::REQ_TICK);
  assign ev_do   = proc && (req_type == lpd_pkg::REQ_EVENT);
  assign pat_on  = (switch_bits == lpd_pkg::PAT_ALT) || (switch_bits == lpd_pkg::PAT_CHASE);

  // saturating tick count and the pattern's interval check
  assign elapsed_inc = (elapsed_ticks == lpd_pkg::ELAPSED_MAX) ? elapsed_ticks
                                                               : elapsed_ticks + 1'b1;
  assign interval    = (switch_bits == lpd_pkg::PAT_ALT) ? cfg.alt_interval
                                                         : cfg.chase_interval;
  assign act         = pat_on && (elapsed_inc >= interval);

  // pwm counter wraps before the compare
  assign pwm_cur = (pwm_count >= cfg.pwm_period) ? '0 : pwm_count;

  // chaser positions: off, first, middle, last (mod led count)
  assign chase_step = (step_index >= STEP_WRAP) ? '0 : step_index;
  always_comb begin
    idx_sum = '0;
    for (int k = 0; k < 4; k++) begin
      idx_sum = (SW + 1)'(chase_step) + (SW + 1)'(k);
      if (idx_sum >= LEDS_EXT) begin
        idx_sum = idx_sum - LEDS_EXT;
      end
      chase_idx[k] = idx_sum[LW-1:0];
    end
  end

  // commands to the led bank
  always_comb begin
    ctl.tick      = tick_do;
    ctl.clear     = tick_do && pat_on && needs_clear;
    ctl.alt_do    = tick_do && act && (switch_bits == lpd_pkg::PAT_ALT);
    ctl.alt_first = (step_index == '0);
    ctl.chase_do  = tick_do && act && (switch_bits == lpd_pkg::PAT_CHASE);
    ctl.pwm_cnt   = pwm_cur;
  end

  // switch bitmap after an event
  always_comb begin
    pattern_next = switch_bits;
    if (ev_do) begin
      for (int b = 0; b < lpd_pkg::PAT_W; b++) begin
        if (switch_index == 2'(b)) begin
          pattern_next[b] = switch_on;
        end
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_bits   <= '0;
      step_index    <= '0;
      elapsed_ticks <= '0;
      pwm_count     <= '0;
      needs_clear   <= 1'b1;
    end else if (ev_do) begin
      switch_bits   <= pattern_next;
      step_index    <= '0;
      needs_clear   <= 1'b1;
      elapsed_ticks <= lpd_pkg::ELAPSED_MAX;
    end else if (tick_do) begin
      elapsed_ticks <= act ? '0 : elapsed_inc;
      pwm_count     <= pwm_cur + 1'b1;
      if (pat_on) begin
        needs_clear <= 1'b0;
      end
      if (ctl.alt_do) begin
        step_index <= (step_index == '0) ? SW'(1) : '0;
      end else if (ctl.chase_do) begin
        step_index <= chase_step + 1'b1;
      end
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_index <= STEP_WRAP)
    else $error("step index beyond chaser wrap");

  a_event_arms: assert property (@(posedge clk) disable iff (rst)
    ev_do |=> needs_clear && (elapsed_ticks == lpd_pkg::ELAPSED_MAX) && (step_index == '0))
    else $error("event did not arm clear and first action");

  a_pwm_advance: assert property (@(posedge clk) disable iff (rst)
    tick_do |=> (pwm_count != '0))
    else $error("pwm count did not advance on tick");

  a_action_resets: assert property (@(posedge clk) disable iff (rst)
    (tick_do && act) |=> (elapsed_ticks == '0))
    else $error("elapsed ticks not cleared by pattern action");

endmodule

`default_nettype wire

>>> rtl/lpd_led_bank.sv
`default_nettype none

module lpd_led_bank #(
  parameter int unsigned NUM_LEDS = 12,
  parameter int unsigned LW       = $clog2(NUM_LEDS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lpd_pkg::led_ctl_t            ctl,
  input  wire logic [3:0][LW-1:0]           chase_idx,
  input  wire logic [lpd_pkg::PWM_W-1:0]    base_duty,
  output logic      [NUM_LEDS-1:0]          lines
);

  logic [NUM_LEDS-1:0][lpd_pkg::DUTY_W-1:0] led_duty;
  logic [NUM_LEDS-1:0][lpd_pkg::DUTY_W-1:0] led_duty_next;
  logic [NUM_LEDS-1:0]                      led_enable;
  logic [NUM_LEDS-1:0]                      led_enable_next;
  logic [lpd_pkg::DUTY_W-1:0]               duty_base;
  logic [lpd_pkg::DUTY_W-1:0]               duty_mid;

  assign duty_base = lpd_pkg::DUTY_W'(base_duty);
  assign duty_mid  = duty_base * lpd_pkg::MIDDLE_GAIN;

  // clear, then pattern action, then pwm compare, all per led
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      led_duty_next[i]   = led_duty[i];
      led_enable_next[i] = led_enable[i];
      if (ctl.clear) begin
        led_duty_next[i]   = duty_base;
        led_enable_next[i] = 1'b0;
      end
      if (ctl.alt_do) begin
        if (ctl.alt_first) begin
          led_duty_next[i]   = duty_base;
          led_enable_next[i] = ~i[0];
        end else begin
          led_enable_next[i] = i[0];
        end
      end
      if (ctl.chase_do) begin
        if (chase_idx[0] == LW'(i)) begin
          led_enable_next[i] = 1'b0;
        end
        if (chase_idx[1] == LW'(i) || chase_idx[3] == LW'(i)) begin
          led_enable_next[i] = 1'b1;
          led_duty_next[i]   = duty_base;
        end
        if (chase_idx[2] == LW'(i)) begin
          led_enable_next[i] = 1'b1;
          led_duty_next[i]   = duty_mid;
        end
      end
      lines[i] = led_enable_next[i] &&
                 (lpd_pkg::DUTY_W'(ctl.pwm_cnt) < led_duty_next[i]);
    end
  end

  // led state
  always_ff @(posedge clk) begin
    if (rst) begin
      led_duty   <= '0;
      led_enable <= '0;
    end else if (ctl.tick) begin
      led_duty   <= led_duty_next;
      led_enable <= led_enable_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/led_pattern_pwm_driver_core.sv
// a request is held in the input register, then its result in the result register on m_tdata
// throughput: one request per cycle unless m_tready stalls it; only a tick updates led state
// a stalled result holds the input register, so s_tready follows m_tready while both are full
// reset (rst, synchronous, active high): leds disabled with zero duty, pattern 0, pending clear
// armed, counters zero, registers at their default values
`default_nettype none

module led_pattern_pwm_driver_core #(
  parameter int unsigned NUM_LEDS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // apb configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [lpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  // request stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,  // switch_index[1:0], switch_on[2]
  input  wire logic                           s_tuser,  // req_type[0]
  // result stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [15:0]                    m_tdata   // led_lines[11:0], active_pattern[14:12]
);

  localparam int unsigned LW = $clog2(NUM_LEDS);
  localparam int unsigned SW = $clog2(NUM_LEDS + 3);

  lpd_pkg::cfg_t     cfg;
  lpd_pkg::led_ctl_t ctl;

  logic                          in_valid;
  logic                          in_req_type;
  logic [1:0]                    in_switch_index;
  logic                          in_switch_on;
  logic                          proc;
  logic [3:0][LW-1:0]            chase_idx;
  logic [lpd_pkg::PAT_W-1:0]     pattern_next;
  logic [NUM_LEDS-1:0]           bank_lines;
  logic [lpd_pkg::LINE_W-1:0]    tick_lines;
  logic [lpd_pkg::LINE_W-1:0]    last_lines;
  logic [lpd_pkg::LINE_W-1:0]    res_lines;

  lpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  assign proc     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req_type     <= s_tuser;
      in_switch_index <= s_tdata[1:0];
      in_switch_on    <= s_tdata[2];
    end
  end

  lpd_seq #(
    .NUM_LEDS (NUM_LEDS),
    .LW       (LW),
    .SW       (SW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .proc         (proc),
    .req_type     (in_req_type),
    .switch_index (in_switch_index),
    .switch_on    (in_switch_on),
    .cfg          (cfg),
    .ctl          (ctl),
    .chase_idx    (chase_idx),
    .pattern_next (pattern_next)
  );

  lpd_led_bank #(
    .NUM_LEDS (NUM_LEDS),
    .LW       (LW)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .chase_idx (chase_idx),
    .base_duty (cfg.base_duty),
    .lines     (bank_lines)
  );

  // leds beyond the visible line count are dropped
  always_comb begin
    tick_lines = '0;
    for (int i = 0; i < lpd_pkg::LINE_W; i++) begin
      if (i < NUM_LEDS) begin
        tick_lines[i] = bank_lines[i];
      end
    end
  end

  assign res_lines = ctl.tick ? tick_lines : last_lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_lines <= '0;
    end else if (ctl.tick) begin
      last_lines <= tick_lines;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_tdata <= {1'b0, pattern_next, res_lines};
    end
  end

endmodule

`default_nettype wire
